FILE: rtl/span_runs_to_bitmap_painter_assert.svh
// Assertion macros shared by the span painter RTL.
`ifndef SPAN_RUNS_TO_BITMAP_PAINTER_ASSERT_SVH
`define SPAN_RUNS_TO_BITMAP_PAINTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srbp_pkg.sv
// Shared types, codes and helper functions of the span painter.
`timescale 1ns / 1ps
`default_nettype none

package srbp_pkg;

  // Default raster size in bytes
  localparam int RASTER_BYTES_DEF = 4096;

  // Configuration register indexes
  localparam logic [2:0] REG_COL_OFFSET    = 3'd0;
  localparam logic [2:0] REG_ROW_OFFSET    = 3'd1;
  localparam logic [2:0] REG_COMP_WIDTH    = 3'd2;
  localparam logic [2:0] REG_COMP_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_RASTER_WIDTH  = 3'd4;
  localparam logic [2:0] REG_RASTER_HEIGHT = 3'd5;
  localparam logic [2:0] REG_PAINT_MODE    = 3'd6;
  localparam logic [2:0] REG_SCALE_SHIFT   = 3'd7;

  // Mask helpers: run of n low ones, and head mask for the last pixel
  localparam logic [15:0] HEAD_MASK = 16'hff00;
  localparam logic [7:0] LOW_ONES [0:8] = '{8'h00, 8'h01, 8'h03, 8'h07, 8'h0f,
                                            8'h1f, 8'h3f, 8'h7f, 8'hff};

  typedef enum logic [1:0] {
    ACT_PAINT,
    ACT_READ,
    ACT_CLEAR,
    ACT_FINISH
  } action_t;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_TRACK,
    MODE_DOUBLE,
    MODE_SCALED
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_BOUNDS,
    STAT_OVERFLOW
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_MUL,
    S_CHECK,
    S_READ,
    S_WRITE,
    S_FETCH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;      // capture a command transfer
    logic    prep;      // register effective end, length and row
    logic    mul;       // row times stride
    logic    check;     // overflow check, set up byte span
    logic    rd_ptr;    // read raster byte at span pointer
    logic    wr_rmw;    // write back byte with run mask
    logic    next_row;  // step base to the second doubled row
    logic    track;     // raise widest end
    logic    clr_wr;    // clearing pass write
    logic    clr_byte;  // clear addressed byte
    logic    rd_addr;   // read addressed byte
    logic    finish;    // finish component
    logic    emit;      // load result registers
    logic    emit_rd;   // result carries read data
    status_t status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    action_t action;
    mode_t   mode;
    logic    bounds_fail;
    logic    addr_bad;
    logic    ovf;
    logic    empty;
    logic    last_byte;
    logic    row2;
    logic    clr_done;
  } sts_t;

  // Row stride in bytes: width rounded up to 64 pixels
  function automatic logic [9:0] stride_of(input logic [11:0] w);
    logic [12:0] r;
    r = {1'b0, w} + 13'd63;
    return {r[12:6], 3'b000};
  endfunction

  // MSB-first mask of pixels first..last within one byte
  function automatic logic [7:0] span_mask(input logic [2:0] first, input logic [2:0] last);
    logic [7:0]  tail;
    logic [15:0] head;
    tail = LOW_ONES[4'd8 - {1'b0, first}];
    head = HEAD_MASK >> ({1'b0, last} + 4'd1);
    return tail & head[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/srbp_dpath.sv
// Datapath of the span painter: registers, run arithmetic and raster memory.
`timescale 1ns / 1ps
`default_nettype none
`include "span_runs_to_bitmap_painter_assert.svh"

module srbp_dpath
  import srbp_pkg::*;
#(
  parameter int RASTER_BYTES = RASTER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [1:0]  in_action,
  input  wire logic [11:0] in_line_row,
  input  wire logic [11:0] in_interval_end,
  input  wire logic [11:0] in_interval_len,
  input  wire logic [11:0] in_byte_address,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_wdata,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_read_byte,
  output logic [11:0]      out_new_width
);

  localparam int AW = $clog2(RASTER_BYTES);
  localparam int BW = AW + 3;
  localparam int PW = 25;
  localparam int EW = 14;
  localparam int LW = 14;
  localparam int RW = 14;
  localparam int SW = ((BW > LW) ? BW : LW) + 1;
  localparam logic [PW-1:0] RB_LIM   = PW'(RASTER_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(RASTER_BYTES - 1);

  // Configuration registers
  logic [11:0] col_r, rowoff_r, cw_r, ch_r, rw_r, rh_r;
  mode_t       mode_r;
  logic [2:0]  shift_r;
  logic [11:0] widest_r;

  // Captured command
  action_t     act_r;
  logic [11:0] lrow_r, iend_r, ilen_r, addr_r;

  // Run registers
  logic [EW-1:0] end_r, end_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] base_r;
  logic [BW-1:0] lo_r, last_r;
  logic [AW-1:0] ptr_r;
  logic          row2_r;
  logic [AW-1:0] clr_cnt_r;

  // Memory and result registers
  logic [7:0]    mem [RASTER_BYTES];
  logic [7:0]    rd_q;
  logic          out_valid_r;
  status_t       out_status_r;
  logic [7:0]    out_read_byte_r;
  logic [11:0]   out_new_width_r;

  logic [9:0]    ww;
  logic [PW-1:0] addr_ext;
  logic          addr_bad;

  assign ww       = stride_of(rw_r);
  assign addr_ext = PW'(addr_r);
  assign addr_bad = addr_ext >= RB_LIM;

  // Configuration writes and width update on finish
  logic        fin_take;
  logic [11:0] nw;

  assign fin_take = (mode_r == MODE_TRACK) && (stride_of(widest_r) == ww);
  assign nw       = fin_take ? widest_r : rw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      rowoff_r <= '0;
      cw_r     <= '0;
      ch_r     <= '0;
      rw_r     <= '0;
      rh_r     <= '0;
      mode_r   <= MODE_PLAIN;
      shift_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COL_OFFSET:    col_r    <= cfg_wdata;
          REG_ROW_OFFSET:    rowoff_r <= cfg_wdata;
          REG_COMP_WIDTH:    cw_r     <= cfg_wdata;
          REG_COMP_HEIGHT:   ch_r     <= cfg_wdata;
          REG_RASTER_WIDTH:  rw_r     <= cfg_wdata;
          REG_RASTER_HEIGHT: rh_r     <= cfg_wdata;
          REG_PAINT_MODE:    mode_r   <= mode_t'(cfg_wdata[1:0]);
          REG_SCALE_SHIFT:   shift_r  <= cfg_wdata[2:0];
          default:           col_r    <= col_r;
        endcase
      end
      if (cmd.finish) begin
        rw_r <= nw;
      end
    end
  end

  // Widest painted end, tracked in mode 1
  logic [11:0] e12;

  assign e12 = (end_r > EW'(4095)) ? 12'hfff : end_r[11:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widest_r <= '0;
    end else if (cmd.finish) begin
      widest_r <= '0;
    end else if (cmd.track && (e12 > widest_r)) begin
      widest_r <= e12;
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action_t'(in_action);
      lrow_r <= in_line_row;
      iend_r <= in_interval_end;
      ilen_r <= in_interval_len;
      addr_r <= in_byte_address;
    end
  end

  // Bounds check against the (scaled) raster size
  logic [18:0] lim_w, lim_h, need_w, need_h;
  logic        bounds_fail;

  always_comb begin
    lim_w  = {7'b0, rw_r};
    lim_h  = {7'b0, rh_r};
    if (mode_r == MODE_SCALED) begin
      lim_w = {7'b0, rw_r} << shift_r;
      lim_h = {7'b0, rh_r} << shift_r;
    end
    need_w = {6'b0, {1'b0, col_r} + {1'b0, cw_r}};
    need_h = {6'b0, {1'b0, rowoff_r} + {1'b0, ch_r}};
    bounds_fail = (cw_r == '0) || (ch_r == '0) || (need_w > lim_w) || (need_h > lim_h);
  end

  // Effective end, length and row per paint mode
  logic [12:0]        e13, r13;
  logic signed [14:0] bsig, bsh, esh, bfix, efix, lsc;

  always_comb begin
    e13  = {1'b0, iend_r} + {1'b0, col_r};
    r13  = {1'b0, lrow_r} + {1'b0, rowoff_r};
    bsig = $signed({2'b00, e13}) - $signed({3'b000, ilen_r});
    bsh  = bsig >>> shift_r;
    esh  = $signed({2'b00, e13 >> shift_r});
    bfix = bsh;
    efix = esh;
    // empty scaled run: widen by one pixel
    if (bsh == esh) begin
      if (bsh != '0) begin
        bfix = bsh - 15'sd1;
      end else begin
        efix = esh + 15'sd1;
      end
    end
    lsc = efix - bfix;
    case (mode_r)
      MODE_SCALED: begin
        end_nxt = efix[EW-1:0];
        len_nxt = lsc[LW-1:0];
        row_nxt = {2'b00, lrow_r >> shift_r};
      end
      MODE_DOUBLE: begin
        end_nxt = {1'b0, iend_r, 1'b0} + {2'b00, col_r};
        len_nxt = {1'b0, ilen_r, 1'b0};
        row_nxt = {r13, 1'b0};
      end
      default: begin
        end_nxt = {1'b0, e13};
        len_nxt = {2'b00, ilen_r};
        row_nxt = {1'b0, r13};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      end_r <= end_nxt;
      len_r <= len_nxt;
      row_r <= row_nxt;
    end
  end

  // Row base: one multiply, then the doubled row one stride on
  logic [23:0] prod;

  assign prod = {10'b0, row_r} * {14'b0, ww};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      base_r <= {1'b0, prod};
    end else if (cmd.next_row) begin
      base_r <= base_r + PW'(ww);
    end
  end

  // Overflow check and pixel span [lo, hi)
  logic [PW-1:0]        end_byte;
  logic [BW-1:0]        hi, lo;
  logic signed [SW-1:0] lo_s;
  logic                 ovf, empty;

  always_comb begin
    end_byte = base_r + PW'(end_r[EW-1:3]);
    ovf      = end_byte >= RB_LIM;
    hi       = {end_byte[AW-1:0], end_r[2:0]};
    lo_s     = $signed(SW'(hi)) - $signed(SW'(len_r));
    lo       = lo_s[SW-1] ? '0 : lo_s[BW-1:0];
    empty    = (len_r == '0) || (hi == '0);
  end

  // Byte walk over the span
  logic [2:0] first_b, last_b;
  logic [7:0] mask;
  logic       last_byte;

  assign first_b   = (ptr_r == lo_r[BW-1:3]) ? lo_r[2:0] : 3'd0;
  assign last_b    = (ptr_r == last_r[BW-1:3]) ? last_r[2:0] : 3'd7;
  assign mask      = span_mask(first_b, last_b);
  assign last_byte = ptr_r == last_r[BW-1:3];

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      lo_r   <= lo;
      last_r <= hi - BW'(1);
      ptr_r  <= lo[BW-1:3];
    end else if (cmd.wr_rmw) begin
      ptr_r  <= ptr_r + AW'(1);
    end
  end

  // Second-row flag and clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row2_r    <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        row2_r <= 1'b0;
      end else if (cmd.next_row) begin
        row2_r <= 1'b1;
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // Raster memory: one write port, one registered read port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  always_comb begin
    we    = cmd.clr_wr || cmd.clr_byte || cmd.wr_rmw;
    waddr = ptr_r;
    wdata = rd_q | mask;
    if (cmd.clr_wr) begin
      waddr = clr_cnt_r;
      wdata = '0;
    end else if (cmd.clr_byte) begin
      waddr = addr_ext[AW-1:0];
      wdata = '0;
    end
    raddr = cmd.rd_addr ? addr_ext[AW-1:0] : ptr_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_ptr || cmd.rd_addr) begin
      rd_q <= mem[raddr];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r    <= cmd.status;
      out_read_byte_r <= cmd.emit_rd ? rd_q : 8'h00;
      out_new_width_r <= cmd.finish ? nw : 12'h000;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_byte = out_read_byte_r;
  assign out_new_width = out_new_width_r;

  // Status to the controller
  always_comb begin
    sts.action      = act_r;
    sts.mode        = mode_r;
    sts.bounds_fail = bounds_fail;
    sts.addr_bad    = addr_bad;
    sts.ovf         = ovf;
    sts.empty       = empty;
    sts.last_byte   = last_byte;
    sts.row2        = row2_r;
    sts.clr_done    = clr_cnt_r == CLR_LAST;
  end

  // Checks
  `SRBP_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe held two cycles")
  `SRBP_ASSERT_NOW(a_ptr_in_span, cmd.wr_rmw, ptr_r <= last_r[BW-1:3], "byte walk ran past span end")
  `SRBP_ASSERT_NOW(a_fail_no_data, out_valid_r && (out_status_r != STAT_OK), (out_new_width_r == 12'h000) && (out_read_byte_r == 8'h00), "failed result carries data")

endmodule

`default_nettype wire

FILE: rtl/srbp_ctrl.sv
// Controller state machine of the span painter.
`timescale 1ns / 1ps
`default_nettype none
`include "span_runs_to_bitmap_painter_assert.svh"

module srbp_ctrl
  import srbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   row_end;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    cmd.status = STAT_OK;
    state_nxt  = state_r;
    row_end    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        case (sts.action)
          ACT_PAINT: begin
            cmd.prep = 1'b1;
            if (sts.bounds_fail) begin
              cmd.emit   = 1'b1;
              cmd.status = STAT_BOUNDS;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_MUL;
            end
          end
          ACT_READ: begin
            if (sts.addr_bad) begin
              cmd.emit   = 1'b1;
              cmd.status = STAT_OVERFLOW;
              state_nxt  = S_IDLE;
            end else begin
              cmd.rd_addr = 1'b1;
              state_nxt   = S_FETCH;
            end
          end
          ACT_CLEAR: begin
            cmd.emit = 1'b1;
            if (sts.addr_bad) begin
              cmd.status = STAT_OVERFLOW;
            end else begin
              cmd.clr_byte = 1'b1;
            end
            state_nxt = S_IDLE;
          end
          default: begin
            cmd.finish = 1'b1;
            cmd.emit   = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.ovf) begin
          cmd.emit   = 1'b1;
          cmd.status = STAT_OVERFLOW;
          state_nxt  = S_IDLE;
        end else if (sts.empty) begin
          row_end = 1'b1;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_ptr = 1'b1;
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_rmw = 1'b1;
        if (sts.last_byte) begin
          row_end = 1'b1;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_FETCH: begin
        cmd.emit    = 1'b1;
        cmd.emit_rd = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Row finished: second doubled row or done
    if (row_end) begin
      if ((sts.mode == MODE_DOUBLE) && !sts.row2) begin
        cmd.next_row = 1'b1;
        state_nxt    = S_CHECK;
      end else begin
        cmd.track = sts.mode == MODE_TRACK;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
    end
  end

  // Checks
  `SRBP_ASSERT_NEXT(a_accept_to_prep, start && !busy, state_r == S_PREP, "accepted command did not enter prep")
  `SRBP_ASSERT_NEXT(a_read_then_write, state_r == S_READ, state_r == S_WRITE, "read not followed by write back")
  `SRBP_ASSERT_NEXT(a_emit_to_idle, cmd.emit, state_r == S_IDLE, "result issued without returning to idle")

endmodule

`default_nettype wire

FILE: rtl/span_runs_to_bitmap_painter.sv
// Top level of the span painter: controller plus datapath with raster memory.
//
// Commands are taken when start is high and busy is low; every command
// gives exactly one result, shown for a single cycle with out_valid and
// never held off by the receiver. After reset the raster memory is zeroed
// by a clearing pass with busy high; configuration writes are taken
// during that pass. A paint steps through prep, multiply and overflow
// check, then reads and writes back each raster byte the run touches,
// since every byte is a read-modify-write through the single memory port
// pair; a doubled paint repeats the check and byte walk for its second
// row. The result appears in the same cycle that busy drops.
`timescale 1ns / 1ps
`default_nettype none

module span_runs_to_bitmap_painter
  import srbp_pkg::*;
#(
  parameter int RASTER_BYTES = RASTER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [11:0] in_line_row,
  input  wire logic [11:0] in_interval_end,
  input  wire logic [11:0] in_interval_len,
  input  wire logic [11:0] in_byte_address,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_read_byte,
  output logic [11:0]      out_new_width,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  srbp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Registers, arithmetic and raster
  srbp_dpath #(
    .RASTER_BYTES (RASTER_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_line_row     (in_line_row),
    .in_interval_end (in_interval_end),
    .in_interval_len (in_interval_len),
    .in_byte_address (in_byte_address),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_byte   (out_read_byte),
    .out_new_width   (out_new_width)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the span painter: directed runs plus random phases.
`timescale 1ns / 1ps

module tb_top;
  import srbp_pkg::*;

  localparam int IMG_BYTES = RASTER_BYTES_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    status_t     status;
    logic [7:0]  rd_byte;
    logic [11:0] width;
  } paint_result_t;

  // DUT connections, all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = '0;
  logic [11:0] in_line_row = '0;
  logic [11:0] in_interval_end = '0;
  logic [11:0] in_interval_len = '0;
  logic [11:0] in_byte_address = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_read_byte;
  logic [11:0] out_new_width;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_wdata = '0;

  // Mirror of the block's registers and raster
  logic [7:0]  raster_img [0:IMG_BYTES-1];
  logic [11:0] m_col_off, m_row_off, m_comp_w, m_comp_h, m_ras_w, m_ras_h;
  mode_t       m_mode;
  logic [2:0]  m_shift;
  logic [11:0] m_widest;
  int          last_touched_byte;

  paint_result_t pending_results [$];
  int            fail_count = 0;
  int            stall_cycles = 0;

  span_runs_to_bitmap_painter #(.RASTER_BYTES(IMG_BYTES)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_line_row     (in_line_row),
    .in_interval_end (in_interval_end),
    .in_interval_len (in_interval_len),
    .in_byte_address (in_byte_address),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_byte   (out_read_byte),
    .out_new_width   (out_new_width),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int lesser(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // Bytes per row: width rounded up to 64 pixels
  function automatic longint row_stride(input longint w);
    return ((w + 64'sd63) >> 6) << 3;
  endfunction

  // OR ones into run_len pixels ending before pixel base*8+end_col
  function automatic bit or_run_bits(input longint base, input longint end_col,
                                     input longint run_len);
    longint top;
    longint k;
    if (base + (end_col >> 3) >= IMG_BYTES)
      return 1'b0;
    last_touched_byte = int'(base + (end_col >> 3));
    top = base * 8 + end_col;
    k = 0;
    while (k < run_len && top > 0) begin
      top = top - 1;
      raster_img[top >> 3] = raster_img[top >> 3] | (8'h80 >> (top & 7));
      k = k + 1;
    end
    return 1'b1;
  endfunction

  function automatic status_t paint_run(input logic [11:0] row_in, input logic [11:0] end_in,
                                        input logic [11:0] len_in);
    longint lim_w, lim_h, ww, col, rowo, re, rl, rr, e, b, row;
    lim_w = m_ras_w;
    lim_h = m_ras_h;
    ww = row_stride(m_ras_w);
    col = m_col_off;
    rowo = m_row_off;
    re = end_in;
    rl = len_in;
    rr = row_in;
    if (m_mode == MODE_SCALED) begin
      lim_w = lim_w << m_shift;
      lim_h = lim_h << m_shift;
    end
    if (m_comp_w == 0 || m_comp_h == 0 || col + longint'(m_comp_w) > lim_w ||
        rowo + longint'(m_comp_h) > lim_h)
      return STAT_BOUNDS;
    case (m_mode)
      MODE_SCALED: begin
        b = (re + col - rl) >>> m_shift;
        e = (re + col) >>> m_shift;
        // empty run still paints one pixel
        if (b == e) begin
          if (b != 0) b = b - 1;
          else e = e + 1;
        end
        row = rr >> m_shift;
        return or_run_bits(row * ww, e, e - b) ? STAT_OK : STAT_OVERFLOW;
      end
      MODE_DOUBLE: begin
        row = rr + rowo;
        e = 2 * re + col;
        if (!or_run_bits(row * ww * 2, e, 2 * rl))
          return STAT_OVERFLOW;
        if (!or_run_bits(row * ww * 2 + ww, e, 2 * rl))
          return STAT_OVERFLOW;
        return STAT_OK;
      end
      default: begin
        row = rr + rowo;
        e = re + col;
        if (!or_run_bits(row * ww, e, rl))
          return STAT_OVERFLOW;
        if (m_mode == MODE_TRACK) begin
          if (e > 4095) e = 4095;
          if (e > longint'(m_widest)) m_widest = e[11:0];
        end
        return STAT_OK;
      end
    endcase
  endfunction

  // Expected result of one accepted command; updates the mirror
  function automatic paint_result_t predict_command(input action_t act,
      input logic [11:0] row_in, input logic [11:0] end_in, input logic [11:0] len_in,
      input logic [11:0] addr);
    paint_result_t res;
    res.status = STAT_OK;
    res.rd_byte = '0;
    res.width = '0;
    case (act)
      ACT_PAINT: res.status = paint_run(row_in, end_in, len_in);
      ACT_READ: begin
        if (addr >= IMG_BYTES) res.status = STAT_OVERFLOW;
        else res.rd_byte = raster_img[addr];
      end
      ACT_CLEAR: begin
        if (addr >= IMG_BYTES) res.status = STAT_OVERFLOW;
        else raster_img[addr] = '0;
      end
      default: begin
        if (m_mode == MODE_TRACK && row_stride(m_widest) == row_stride(m_ras_w))
          m_ras_w = m_widest;
        res.width = m_ras_w;
        m_widest = '0;
      end
    endcase
    return res;
  endfunction

  // One command transfer; returns at the edge that accepted it, start left high
  task automatic send_cmd(input action_t act, input int row_in, input int end_in,
                          input int len_in, input int addr);
    in_action <= act;
    in_line_row <= row_in[11:0];
    in_interval_end <= end_in[11:0];
    in_interval_len <= len_in[11:0];
    in_byte_address <= addr[11:0];
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(predict_command(act, row_in[11:0], end_in[11:0],
                                              len_in[11:0], addr[11:0]));
  endtask

  // Sender gap with junk on the command fields
  task automatic pause_sender(input int n);
    start <= 1'b0;
    in_action <= 2'($urandom());
    in_line_row <= 12'($urandom());
    in_interval_end <= 12'($urandom());
    in_interval_len <= 12'($urandom());
    in_byte_address <= 12'($urandom());
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_COL_OFFSET:    m_col_off = val;
      REG_ROW_OFFSET:    m_row_off = val;
      REG_COMP_WIDTH:    m_comp_w = val;
      REG_COMP_HEIGHT:   m_comp_h = val;
      REG_RASTER_WIDTH:  m_ras_w = val;
      REG_RASTER_HEIGHT: m_ras_h = val;
      REG_PAINT_MODE:    m_mode = mode_t'(val[1:0]);
      default:           m_shift = val[2:0];
    endcase
  endtask

  // Writes every register; narrow ones get junk in the unused upper bits
  task automatic load_config(input int col, input int rowo, input int cw, input int ch,
                             input int rw, input int rh, input logic [1:0] md,
                             input logic [2:0] sh);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(REG_COL_OFFSET, col[11:0]);
    write_reg(REG_ROW_OFFSET, rowo[11:0]);
    write_reg(REG_COMP_WIDTH, cw[11:0]);
    write_reg(REG_COMP_HEIGHT, ch[11:0]);
    write_reg(REG_RASTER_WIDTH, rw[11:0]);
    write_reg(REG_RASTER_HEIGHT, rh[11:0]);
    write_reg(REG_PAINT_MODE, {junk[9:0], md});
    write_reg(REG_SCALE_SHIFT, {junk[20:12], sh});
    cfg_we <= 1'b0;
  endtask

  // Reset configuration: zero component size rejects every paint
  task automatic test_reset_bounds;
    send_cmd(ACT_PAINT, 0, 8, 8, 0);
    send_cmd(ACT_READ, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_plain_paint;
    load_config(0, 0, 32, 32, 64, 64, MODE_PLAIN, 3'd0);
    send_cmd(ACT_PAINT, 0, 8, 8, 0);
    send_cmd(ACT_READ, 0, 0, 0, 0);
    // run longer than its end column spills into the row above
    send_cmd(ACT_PAINT, 1, 20, 30, 0);
    // spill past pixel zero is dropped
    send_cmd(ACT_PAINT, 0, 5, 100, 0);
    send_cmd(ACT_PAINT, 2, 10, 0, 0);
    send_cmd(ACT_PAINT, 4095, 4095, 4095, 4095);
    send_cmd(ACT_READ, 0, 0, 0, 8);
    send_cmd(ACT_CLEAR, 0, 0, 0, 0);
    send_cmd(ACT_READ, 0, 0, 0, 0);
    send_cmd(ACT_FINISH, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_width_tracking;
    load_config(0, 0, 32, 32, 64, 64, MODE_TRACK, 3'd0);
    send_cmd(ACT_PAINT, 0, 40, 3, 0);
    // widest end lands in a wider stride: width kept
    send_cmd(ACT_PAINT, 0, 70, 1, 0);
    send_cmd(ACT_FINISH, 0, 0, 0, 0);
    send_cmd(ACT_PAINT, 3, 50, 2, 0);
    send_cmd(ACT_FINISH, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_doubled_rows;
    load_config(1, 0, 8, 8, 64, 64, MODE_DOUBLE, 3'd0);
    send_cmd(ACT_PAINT, 1, 3, 2, 0);
    send_cmd(ACT_READ, 0, 0, 0, 16);
    // first row fits, second row overflows
    send_cmd(ACT_PAINT, 255, 60, 4, 0);
    send_cmd(ACT_READ, 0, 0, 0, 4095);
    drain();
  endtask

  task automatic test_scaled_runs;
    load_config(3, 5, 60, 60, 16, 16, MODE_SCALED, 3'd2);
    // empty run at column zero; the bounds check rejects it, as row offset plus height exceeds the scaled height
    send_cmd(ACT_PAINT, 0, 0, 0, 0);
    // empty run elsewhere, also rejected by the bounds check
    send_cmd(ACT_PAINT, 8, 61, 0, 0);
    // begin below zero after the shift, also rejected by the bounds check
    send_cmd(ACT_PAINT, 0, 0, 10, 0);
    drain();
  endtask

  task automatic test_bounds_extremes;
    load_config(4095, 4095, 4095, 4095, 4095, 4095, MODE_SCALED, 3'd7);
    send_cmd(ACT_PAINT, 4095, 4095, 4095, 0);
    drain();
    load_config(4095, 0, 1, 1, 4095, 4095, MODE_PLAIN, 3'd0);
    send_cmd(ACT_PAINT, 0, 1, 1, 0);
    drain();
    load_config(0, 0, 0, 4095, 4095, 4095, MODE_TRACK, 3'd0);
    send_cmd(ACT_PAINT, 0, 1, 1, 0);
    drain();
  endtask

  // Random phases: fresh configuration, then a mix of mostly well-formed commands
  task automatic test_random_phases(input int n_phases, input int n_items);
    int      ph, n, pick, rows, span, ww, lim_w, lim_h;
    int      col, rowo, cw, ch, rw, rh, row_f, end_f, len_f, addr_f;
    logic [1:0] md;
    logic [2:0] sh;
    bit      idle_on;
    action_t act;
    for (ph = 0; ph < n_phases; ph++) begin
      md = 2'(ph % 4);
      sh = (ph == 3) ? 3'd7 : 3'($urandom_range(0, 7));
      if (ph == 1 || ph == 3) rw = 4095;
      else if (ph == 5) rw = $urandom_range(1, 8);
      else if ($urandom_range(0, 1) == 0) rw = $urandom_range(1, 256);
      else rw = $urandom_range(1, 4095);
      rh = (ph == 1 || ph == 3) ? 4095 : $urandom_range(1, 4095);
      lim_w = (md == MODE_SCALED) ? (rw << sh) : rw;
      lim_h = (md == MODE_SCALED) ? (rh << sh) : rh;
      if (ph == 3) col = 4095;
      else if ($urandom_range(0, 9) < 6) col = $urandom_range(0, lesser(15, lim_w - 1));
      else col = $urandom_range(0, lesser(4095, lim_w - 1));
      cw = $urandom_range(1, lesser(4095, lim_w - col));
      if ($urandom_range(0, 9) < 7) rowo = $urandom_range(0, lesser(7, lim_h - 1));
      else rowo = $urandom_range(0, lesser(4095, lim_h - 1));
      ch = $urandom_range(1, lesser(4095, lim_h - rowo));
      if (ph == 3) cw = 4095;
      // now and then a component that fails the bounds check
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) cw = 0;
        else ch = 0;
      end
      load_config(col, rowo, cw, ch, rw, rh, md, sh);

      idle_on = 1'b0;
      for (n = 0; n < n_items; n++) begin
        if (n % 16 == 0) idle_on = (ph != n_phases - 1) && ($urandom_range(0, 2) != 0);
        if (idle_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 6));
        pick = $urandom_range(0, 99);
        row_f = $urandom_range(0, 4095);
        end_f = $urandom_range(0, 4095);
        len_f = $urandom_range(0, 4095);
        addr_f = $urandom_range(0, 4095);
        if (pick < 60) begin
          act = ACT_PAINT;
          if ($urandom_range(0, 9) < 8) begin
            ww = int'(row_stride(m_ras_w));
            rows = (ww == 0) ? 4096 : 4096 / ww;
            if (m_mode == MODE_DOUBLE) rows = rows / 2;
            if (m_mode == MODE_SCALED) begin
              row_f = $urandom_range(0, lesser(4095, ((rows + 1) << m_shift) - 1));
              span = int'(m_ras_w) << m_shift;
            end else begin
              row_f = $urandom_range(0, lesser(4095, rows));
              span = (m_mode == MODE_DOUBLE) ? int'(m_ras_w) / 2 : int'(m_ras_w);
            end
            end_f = $urandom_range(0, lesser(4095, span));
            pick = $urandom_range(0, 9);
            if (pick < 7) len_f = $urandom_range(0, 40);
            else if (pick < 9) len_f = $urandom_range(0, lesser(4095, end_f + 16));
          end
        end else begin
          if (pick < 80) act = ACT_READ;
          else if (pick < 88) act = ACT_CLEAR;
          else act = ACT_FINISH;
          if ($urandom_range(0, 9) < 6) begin
            addr_f = last_touched_byte - $urandom_range(0, 3);
            if (addr_f < 0) addr_f = 0;
          end
        end
        send_cmd(act, row_f, end_f, len_f, addr_f);
      end
      drain();
    end
  endtask

  // Result checker: every strobe must match the oldest pending expectation
  always @(posedge clk) begin
    paint_result_t exp_res;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending: status %0d byte %h width %0d",
                 $time, out_status, out_read_byte, out_new_width);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_res.status, out_status);
          fail_count++;
        end
        if (out_read_byte !== exp_res.rd_byte) begin
          $display("%0t: read_byte mismatch, expected %h actual %h",
                   $time, exp_res.rd_byte, out_read_byte);
          fail_count++;
        end
        if (out_new_width !== exp_res.width) begin
          $display("%0t: new_width mismatch, expected %0d actual %0d",
                   $time, exp_res.width, out_new_width);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL span_runs_to_bitmap_painter");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < IMG_BYTES; i++) raster_img[i] = '0;
    m_col_off = '0; m_row_off = '0; m_comp_w = '0; m_comp_h = '0;
    m_ras_w = '0; m_ras_h = '0; m_mode = MODE_PLAIN; m_shift = '0; m_widest = '0;
    last_touched_byte = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_bounds();
    test_plain_paint();
    test_width_tracking();
    test_doubled_rows();
    test_scaled_runs();
    test_bounds_extremes();
    test_random_phases(10, 88);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("PASS span_runs_to_bitmap_painter");
    else
      $display("FAIL span_runs_to_bitmap_painter");
    $finish;
  end

endmodule
